[design/kcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcf_pkg
// Shared sizes, codes and types of the kernel correlation filter.
// ----------------------------------------------------------------------------
package kcf_pkg;

    // store geometry
    localparam int MAX_IMAGE_WIDTH  = 64;
    localparam int MAX_IMAGE_HEIGHT = 64;
    localparam int MAX_KERNEL_SIZE  = 7;
    localparam int CENTRE_DIVISOR   = 2;

    // field widths
    localparam int OP_W       = 2;
    localparam int COL_W      = 6;
    localparam int ROW_W      = 6;
    localparam int VALUE_W    = 16;
    localparam int FRAC_W     = 8;
    localparam int IMG_DIM_W  = 7;
    localparam int KER_DIM_W  = 3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // request operations
    typedef enum logic [OP_W-1:0] {
        OP_WRITE_PIXEL = 2'd0,
        OP_WRITE_COEF  = 2'd1,
        OP_COMPUTE     = 2'd2,
        OP_NONE        = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_WIDTH  = 3'd2,
        CFG_KERNEL_HEIGHT = 3'd3,
        CFG_FLIP_KERNEL   = 3'd4,
        CFG_NORMALIZE     = 3'd5
    } t_cfg_idx;

endpackage

[design/kcf_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcf_in_if
// Request channel: store writes and compute requests.
// ----------------------------------------------------------------------------
interface kcf_in_if;
    import kcf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic [COL_W-1:0]          col;
    logic [ROW_W-1:0]          row;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output op, output col, output row, output value,
                    input ready);
    modport sink   (input valid, input op, input col, input row, input value,
                    output ready);
endinterface

[design/kcf_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcf_out_if
// Result channel: filtered pixel and clip flag.
// ----------------------------------------------------------------------------
interface kcf_out_if;
    import kcf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] result_pixel;
    logic                      saturated;

    modport source (output valid, output result_pixel, output saturated, input ready);
    modport sink   (input valid, input result_pixel, input saturated, output ready);
endinterface

[design/kernel_correlation_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kernel_correlation_filter
// Zero-padded 2D correlation / convolution over a stored Q8.8 image and kernel.
//
//   channel   dir  requests                         payload
//   i_in      in   pixel write, coef write, compute op, col, row, value
//   o_out     out  one per compute request          result_pixel, saturated
//   i_cfg_*   in   register write                   index, data
//
// A compute request steps through every kernel tap, then the area divide when
// area normalization is on: one pixel/coefficient pair a cycle
// goes through the single multiply-accumulate behind the registered store
// reads, and the area divide retires two quotient bits a cycle.
// Reset is synchronous and active low; it clears control and configuration,
// not the stores. A finished result waits in the output register while new
// requests are taken; a compute request stalls at its end only if that
// register is still full.
// ----------------------------------------------------------------------------
module kernel_correlation_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kcf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kcf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    kcf_in_if.sink                          i_in,
    kcf_out_if.source                       o_out
);
    import kcf_pkg::*;

    localparam int PIX_DEPTH = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int X_AW      = $clog2(MAX_IMAGE_WIDTH);
    localparam int Y_AW      = $clog2(MAX_IMAGE_HEIGHT);
    localparam int COEF_DEPTH = MAX_KERNEL_SIZE * MAX_KERNEL_SIZE;
    localparam int COEF_AW   = $clog2(COEF_DEPTH);
    localparam int K_W       = $clog2(MAX_KERNEL_SIZE + 1);
    localparam int AREA_W    = $clog2(COEF_DEPTH + 1);
    localparam int REM_W     = AREA_W + 1;
    localparam int CRD_W     = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;
    localparam int PROD_W    = 2 * VALUE_W;
    localparam int ACC_W     = PROD_W + $clog2(COEF_DEPTH);
    localparam int T_W       = ACC_W - FRAC_W;
    localparam int DIV_STEPS = (T_W + 1) / 2;
    localparam int DQ_W      = 2 * DIV_STEPS;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int RES_MAX   = 2 ** (VALUE_W - 1) - 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RUN   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_FIN   = 5'b10000
    } t_state;

    // configuration registers
    logic [IMG_DIM_W-1:0] r_img_w, r_img_h;
    logic [KER_DIM_W-1:0] r_ker_w, r_ker_h;
    logic                 r_flip, r_norm;

    // control
    t_state               r_state, n_state;
    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;
    logic [K_W-1:0]       r_ki, n_ki, r_kj, n_kj;
    logic [STEP_W-1:0]    r_step, n_step;
    logic                 r_neg, n_neg;
    logic [DQ_W-1:0]      r_dq, n_dq;
    logic [REM_W-1:0]     r_rem, n_rem;

    // read and multiply-accumulate pipeline
    logic                      r_rd_vld, r_rd_in, r_prod_vld;
    logic signed [VALUE_W-1:0] r_pix_q, r_coef_q;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    // stores
    logic signed [VALUE_W-1:0] r_pix_mem  [PIX_DEPTH];
    logic signed [VALUE_W-1:0] r_coef_mem [COEF_DEPTH];

    // output register
    logic                      r_out_vld;
    logic signed [VALUE_W-1:0] r_out_pix;
    logic                      r_out_sat;

    // combinational
    logic                 in_acc, pix_we, coef_we, start, out_free, fin_load;
    logic [K_W-1:0]       kw, kh, ci, cj, xs, ys;
    logic [IMG_DIM_W-1:0] iw, ih;
    logic [AREA_W-1:0]    area;
    logic [CRD_W-1:0]     x_s, y_s;
    logic                 rd_in;
    logic [PIX_AW-1:0]    pix_waddr, pix_raddr;
    logic [COEF_AW-1:0]   coef_waddr, coef_raddr;
    logic [ACC_W-1:0]     acc_mag;
    logic [VALUE_W-1:0]   q16;
    logic signed [VALUE_W-1:0] fin_pix;
    logic                 fin_sat;
    logic                 last_tap;

    // request handshake
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign start      = in_acc && (i_in.op == OP_COMPUTE);
    assign pix_we     = in_acc && (i_in.op == OP_WRITE_PIXEL)
                        && ({1'b0, i_in.col} < (COL_W + 1)'(MAX_IMAGE_WIDTH))
                        && ({1'b0, i_in.row} < (ROW_W + 1)'(MAX_IMAGE_HEIGHT));
    assign coef_we    = in_acc && (i_in.op == OP_WRITE_COEF)
                        && (i_in.col < COL_W'(MAX_KERNEL_SIZE))
                        && (i_in.row < ROW_W'(MAX_KERNEL_SIZE));
    assign pix_waddr  = PIX_AW'(i_in.row * MAX_IMAGE_WIDTH + i_in.col);
    assign coef_waddr = COEF_AW'(i_in.row * MAX_KERNEL_SIZE + i_in.col);

    // effective sizes
    always_comb begin
        kw = (r_ker_w == '0) ? K_W'(1)
           : ((r_ker_w > KER_DIM_W'(MAX_KERNEL_SIZE)) ? K_W'(MAX_KERNEL_SIZE) : K_W'(r_ker_w));
        kh = (r_ker_h == '0) ? K_W'(1)
           : ((r_ker_h > KER_DIM_W'(MAX_KERNEL_SIZE)) ? K_W'(MAX_KERNEL_SIZE) : K_W'(r_ker_h));
        iw = (r_img_w > IMG_DIM_W'(MAX_IMAGE_WIDTH)) ? IMG_DIM_W'(MAX_IMAGE_WIDTH) : r_img_w;
        ih = (r_img_h > IMG_DIM_W'(MAX_IMAGE_HEIGHT)) ? IMG_DIM_W'(MAX_IMAGE_HEIGHT) : r_img_h;
        xs = K_W'(kw / CENTRE_DIVISOR);
        ys = K_W'(kh / CENTRE_DIVISOR);
        area = AREA_W'(kw) * AREA_W'(kh);
    end

    // tap address generation
    always_comb begin
        ci = r_flip ? K_W'(kw - K_W'(1) - r_ki) : r_ki;
        cj = r_flip ? K_W'(kh - K_W'(1) - r_kj) : r_kj;
        coef_raddr = COEF_AW'(cj * MAX_KERNEL_SIZE + ci);
        x_s = CRD_W'(r_col) + CRD_W'(r_ki) - CRD_W'(xs);
        y_s = CRD_W'(r_row) + CRD_W'(r_kj) - CRD_W'(ys);
        rd_in = !x_s[CRD_W-1] && (x_s < CRD_W'(iw))
             && !y_s[CRD_W-1] && (y_s < CRD_W'(ih));
        pix_raddr = PIX_AW'(y_s[Y_AW-1:0] * MAX_IMAGE_WIDTH + x_s[X_AW-1:0]);
        last_tap = (r_ki == K_W'(kw - K_W'(1))) && (r_kj == K_W'(kh - K_W'(1)));
    end

    // magnitude of the sum and final saturation
    always_comb begin
        acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        q16     = r_dq[VALUE_W-1:0];
        if (r_neg) begin
            fin_sat = (r_dq > DQ_W'(RES_MAX + 1));
            fin_pix = fin_sat ? $signed(VALUE_W'(RES_MAX + 1)) : $signed((~q16) + VALUE_W'(1));
        end else begin
            fin_sat = (r_dq > DQ_W'(RES_MAX));
            fin_pix = fin_sat ? $signed(VALUE_W'(RES_MAX)) : $signed(q16);
        end
    end

    assign out_free = !r_out_vld || o_out.ready;
    assign fin_load = (r_state == ST_FIN) && out_free;

    // sequencer and area divider
    always_comb begin
        n_state = r_state;
        n_ki    = r_ki;
        n_kj    = r_kj;
        n_step  = r_step;
        n_neg   = r_neg;
        n_dq    = r_dq;
        n_rem   = r_rem;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_ki    = '0;
                    n_kj    = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_tap) begin
                    n_state = ST_DRAIN;
                end else if (r_ki == K_W'(kw - K_W'(1))) begin
                    n_ki = '0;
                    n_kj = r_kj + K_W'(1);
                end else begin
                    n_ki = r_ki + K_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !r_prod_vld) begin
                    n_neg   = r_acc[ACC_W-1];
                    n_dq    = DQ_W'(acc_mag >> FRAC_W);
                    n_rem   = '0;
                    n_step  = STEP_W'(DIV_STEPS - 1);
                    n_state = r_norm ? ST_DIV : ST_FIN;
                end
            end
            ST_DIV: begin
                // two restoring steps per cycle
                for (int k = 0; k < 2; k++) begin
                    n_rem = {n_rem[REM_W-2:0], n_dq[DQ_W-1]};
                    n_dq  = {n_dq[DQ_W-2:0], 1'b0};
                    if (n_rem >= REM_W'(area)) begin
                        n_rem   = n_rem - REM_W'(area);
                        n_dq[0] = 1'b1;
                    end
                end
                if (r_step == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_img_w    <= IMG_DIM_W'(64);
            r_img_h    <= IMG_DIM_W'(64);
            r_ker_w    <= KER_DIM_W'(3);
            r_ker_h    <= KER_DIM_W'(3);
            r_flip     <= 1'b0;
            r_norm     <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= (r_state == ST_RUN);
            r_prod_vld <= r_rd_vld;
            if (fin_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:   r_img_w <= i_cfg_data[IMG_DIM_W-1:0];
                    CFG_IMAGE_HEIGHT:  r_img_h <= i_cfg_data[IMG_DIM_W-1:0];
                    CFG_KERNEL_WIDTH:  r_ker_w <= i_cfg_data[KER_DIM_W-1:0];
                    CFG_KERNEL_HEIGHT: r_ker_h <= i_cfg_data[KER_DIM_W-1:0];
                    CFG_FLIP_KERNEL:   r_flip  <= i_cfg_data[0];
                    CFG_NORMALIZE:     r_norm  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_ki    <= n_ki;
        r_kj    <= n_kj;
        r_step  <= n_step;
        r_neg   <= n_neg;
        r_dq    <= n_dq;
        r_rem   <= n_rem;
        r_rd_in <= rd_in;
        r_prod  <= r_coef_q * (r_rd_in ? r_pix_q : 16'sd0);
        if (start) begin
            r_col <= i_in.col;
            r_row <= i_in.row;
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (fin_load) begin
            r_out_pix <= fin_pix;
            r_out_sat <= fin_sat;
        end
    end

    // pixel store
    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            r_pix_mem[pix_waddr] <= i_in.value;
        end
        r_pix_q <= r_pix_mem[pix_raddr];
    end

    // coefficient store
    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[coef_waddr] <= i_in.value;
        end
        r_coef_q <= r_coef_mem[coef_raddr];
    end

    // result channel
    assign o_out.valid        = r_out_vld;
    assign o_out.result_pixel = r_out_pix;
    assign o_out.saturated    = r_out_sat;

endmodule
